/* src/cts_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_pkg
// Shared constants and types for the cartesian-to-spherical converter:
// CORDIC arctangent table, gain correction factor and per-point flags.
// ---------------------------------------------------------------------------
package cts_pkg;

  // Working coordinates carry this many extra fraction bits
  localparam int GUARD_BITS = 6;

  // Angle accumulator: 2^31 means pi, two spare bits for sign and overshoot
  localparam int ACC_W = 34;
  localparam logic signed [ACC_W-1:0] ACC_PI = 34'sh080000000;

  // Inverse of the limit CORDIC gain (about 0.60725), scaled by 2^24
  localparam int GAIN_W = 24;
  localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10187999;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Properties of the input point that pick the special cases
  typedef struct packed {
    logic y_zero;
    logic x_neg;
    logic xy_zero;
    logic z_pos;
    logic z_neg;
  } cts_meta_t;

endpackage

/* src/cts_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_in_if
// Input channel: one cartesian point per transaction.
// ---------------------------------------------------------------------------
interface cts_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

/* src/cts_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_out_if
// Output channel: one spherical result per transaction.
// ---------------------------------------------------------------------------
interface cts_out_if #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH-1:0] radius;
  logic        [ANGLE_WIDTH-1:0] polar_angle;
  logic signed [ANGLE_WIDTH-1:0] azimuth;

  modport source (output valid, radius, polar_angle, azimuth, input ready);
  modport sink   (input valid, radius, polar_angle, azimuth, output ready);
endinterface

/* src/cartesian_to_spherical.sv */
`timescale 1ns / 1ps
// Throughput: one point per cycle; the whole pipeline advances on one enable,
// so a stalled output freezes every stage and nothing is lost or repeated.
// Depth is set by the two CORDIC vectoring chains, one register per stage.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
// ---------------------------------------------------------------------------
// cartesian_to_spherical
// Pipelined conversion of (x, y, z) into radius, polar angle and azimuth by
// two CORDIC vectoring passes: (x, y) -> rho, phi; then (z, rho) -> r, theta.
// ---------------------------------------------------------------------------
module cartesian_to_spherical
  import cts_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic       clk,
  input logic       rst,
  cts_in_if.sink    in_ch,
  cts_out_if.source out_ch
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int N    = CORDIC_STAGES;
  localparam int W    = CW + 9;          // signed working width
  localparam int RW   = W - 1;           // unsigned length width
  localparam int LO_W = RW / 2;
  localparam int HI_W = RW - LO_W;
  localparam int SW   = RW + GAIN_W + 1; // gain product plus rounding
  localparam int SH   = 32 - AW;
  localparam int EXT  = W - CW - GUARD_BITS;
  localparam logic signed [ACC_W-1:0] HALF =
    (SH > 0) ? ACC_W'(1) << ((SH > 0) ? SH - 1 : 0) : '0;
  localparam logic signed [ACC_W-1:0] PI_CMP = ACC_W'(1) << (AW - 1);
  localparam logic [AW-1:0] PI_ANG  = AW'(1) << (AW - 1);
  localparam logic [AW-1:0] HPI_ANG = AW'(1) << (AW - 2);
  localparam logic [SW-1:0] RND1 = SW'(1) << (GAIN_W - 1);
  localparam logic [SW-1:0] RND2 = SW'(1) << (GAIN_W - 1 + GUARD_BITS);
  localparam logic [CW+2:0] R_MAX = {3'b000, {CW{1'b1}}};

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- pass one: (x, y) ----------------
  logic signed [W-1:0]     ax   [0:N];
  logic signed [W-1:0]     ay   [0:N];
  logic signed [ACC_W-1:0] aacc [0:N];
  logic signed [CW-1:0]    az   [0:N];
  cts_meta_t               am   [0:N];
  logic                    av   [0:N];

  logic signed [W-1:0] xs, ys;
  cts_meta_t           in_meta;

  always_comb begin
    xs = {{EXT{in_ch.x_coord[CW-1]}}, in_ch.x_coord, {GUARD_BITS{1'b0}}};
    ys = {{EXT{in_ch.y_coord[CW-1]}}, in_ch.y_coord, {GUARD_BITS{1'b0}}};
    in_meta.y_zero  = (in_ch.y_coord == '0);
    in_meta.x_neg   = in_ch.x_coord[CW-1];
    in_meta.xy_zero = (in_ch.y_coord == '0) && (in_ch.x_coord == '0);
    in_meta.z_neg   = in_ch.z_coord[CW-1];
    in_meta.z_pos   = !in_ch.z_coord[CW-1] && (in_ch.z_coord != '0);
  end

  // fold the left half-plane onto x >= 0, start the angle at +/- pi
  always_ff @(posedge clk) begin
    if (rst) begin
      av[0] <= 1'b0;
    end else if (en) begin
      av[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax[0] <= in_meta.x_neg ? -xs : xs;
      ay[0] <= in_meta.x_neg ? -ys : ys;
      if (!in_meta.x_neg) begin
        aacc[0] <= '0;
      end else begin
        aacc[0] <= ys[W-1] ? -ACC_PI : ACC_PI;
      end
      az[0] <= in_ch.z_coord;
      am[0] <= in_meta;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_pass1
    localparam logic signed [ACC_W-1:0] ATN = ACC_W'(ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        av[i+1] <= 1'b0;
      end else if (en) begin
        av[i+1] <= av[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ay[i][W-1]) begin
          ax[i+1]   <= ax[i] + (ay[i] >>> i);
          ay[i+1]   <= ay[i] - (ax[i] >>> i);
          aacc[i+1] <= aacc[i] + ATN;
        end else begin
          ax[i+1]   <= ax[i] - (ay[i] >>> i);
          ay[i+1]   <= ay[i] + (ax[i] >>> i);
          aacc[i+1] <= aacc[i] - ATN;
        end
        az[i+1] <= az[i];
        am[i+1] <= am[i];
      end
    end
  end

  // ---------------- gain correction of rho, azimuth rounding ----------------
  logic [RW-1:0]          raw1;
  logic signed [ACC_W-1:0] phi_full;
  logic [AW-1:0]          phi_sel;

  always_comb begin
    raw1     = (ax[N] > 0) ? ax[N][RW-1:0] : '0;
    phi_full = (aacc[N] + HALF) >>> SH;
    if (am[N].y_zero) begin
      phi_sel = am[N].x_neg ? PI_ANG : '0;
    end else begin
      phi_sel = phi_full[AW-1:0];
    end
  end

  logic [LO_W+GAIN_W-1:0] lo1;
  logic [HI_W+GAIN_W-1:0] hi1;
  logic [AW-1:0]          phi_m1;
  logic signed [CW-1:0]   z_m1;
  cts_meta_t              meta_m1;
  logic                   v_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
    end else if (en) begin
      v_m1 <= av[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1     <= raw1[LO_W-1:0] * INV_GAIN;
      hi1     <= raw1[RW-1:LO_W] * INV_GAIN;
      phi_m1  <= phi_sel;
      z_m1    <= az[N];
      meta_m1 <= am[N];
    end
  end

  // ---------------- pass two: (z, rho) ----------------
  logic signed [W-1:0]     bx   [0:N];
  logic signed [W-1:0]     by   [0:N];
  logic signed [ACC_W-1:0] bacc [0:N];
  logic [AW-1:0]           bphi [0:N];
  cts_meta_t               bm   [0:N];
  logic                    bv   [0:N];

  logic [SW-1:0]       sum1;
  logic signed [W-1:0] rho;
  logic signed [W-1:0] zs;

  always_comb begin
    sum1 = {{(SW-HI_W-GAIN_W-LO_W){1'b0}}, hi1, {LO_W{1'b0}}}
         + SW'(lo1) + RND1;
    rho  = signed'(sum1[GAIN_W +: W]);
    zs   = {{EXT{z_m1[CW-1]}}, z_m1, {GUARD_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else if (en) begin
      bv[0] <= v_m1;
    end
  end

  // rho is never negative, so a folded vector always starts at +pi
  always_ff @(posedge clk) begin
    if (en) begin
      bx[0]   <= meta_m1.z_neg ? -zs : zs;
      by[0]   <= meta_m1.z_neg ? -rho : rho;
      bacc[0] <= meta_m1.z_neg ? ACC_PI : '0;
      bphi[0] <= phi_m1;
      bm[0]   <= meta_m1;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_pass2
    localparam logic signed [ACC_W-1:0] ATN = ACC_W'(ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        bv[i+1] <= 1'b0;
      end else if (en) begin
        bv[i+1] <= bv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!by[i][W-1]) begin
          bx[i+1]   <= bx[i] + (by[i] >>> i);
          by[i+1]   <= by[i] - (bx[i] >>> i);
          bacc[i+1] <= bacc[i] + ATN;
        end else begin
          bx[i+1]   <= bx[i] - (by[i] >>> i);
          by[i+1]   <= by[i] + (bx[i] >>> i);
          bacc[i+1] <= bacc[i] - ATN;
        end
        bphi[i+1] <= bphi[i];
        bm[i+1]   <= bm[i];
      end
    end
  end

  // ---------------- gain correction of r, polar angle clamp ----------------
  logic [RW-1:0]           raw2;
  logic signed [ACC_W-1:0] th_full;
  logic [AW-1:0]           th_sel;

  always_comb begin
    raw2    = (bx[N] > 0) ? bx[N][RW-1:0] : '0;
    th_full = (bacc[N] + HALF) >>> SH;
    if (th_full < 0) begin
      th_sel = '0;
    end else if (th_full > PI_CMP) begin
      th_sel = PI_ANG;
    end else begin
      th_sel = th_full[AW-1:0];
    end
    // on the z axis the angle is exact
    if (bm[N].xy_zero) begin
      if (bm[N].z_pos) begin
        th_sel = '0;
      end else if (bm[N].z_neg) begin
        th_sel = PI_ANG;
      end else begin
        th_sel = HPI_ANG;
      end
    end
  end

  logic [LO_W+GAIN_W-1:0] lo2;
  logic [HI_W+GAIN_W-1:0] hi2;
  logic [AW-1:0]          th_m2;
  logic [AW-1:0]          phi_m2;
  logic                   origin_m2;
  logic                   v_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m2 <= 1'b0;
    end else if (en) begin
      v_m2 <= bv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo2       <= raw2[LO_W-1:0] * INV_GAIN;
      hi2       <= raw2[RW-1:LO_W] * INV_GAIN;
      th_m2     <= th_sel;
      phi_m2    <= bphi[N];
      origin_m2 <= bm[N].xy_zero && !bm[N].z_pos && !bm[N].z_neg;
    end
  end

  // ---------------- output register ----------------
  logic [SW-1:0]   sum2;
  logic [CW+2:0]   r_full;
  logic [CW-1:0]   r_sel;

  always_comb begin
    sum2   = {{(SW-HI_W-GAIN_W-LO_W){1'b0}}, hi2, {LO_W{1'b0}}}
           + SW'(lo2) + RND2;
    r_full = sum2[GAIN_W+GUARD_BITS +: CW+3];
    if (origin_m2) begin
      r_sel = '0;
    end else if (r_full > R_MAX) begin
      r_sel = '1;
    end else begin
      r_sel = r_full[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= v_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.radius      <= r_sel;
      out_ch.polar_angle <= th_m2;
      out_ch.azimuth     <= signed'(phi_m2);
    end
  end

  // ---------------- assertions ----------------
  a_theta_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.polar_angle <= PI_ANG)
    else $error("polar angle above pi");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    en && v_m2 && origin_m2 |=>
      out_ch.radius == '0 && out_ch.polar_angle == HPI_ANG && out_ch.azimuth == '0)
    else $error("origin result wrong");

  a_x_axis: assert property (@(posedge clk) disable iff (rst)
    en && av[N] && am[N].y_zero && !am[N].x_neg |=> phi_m1 == '0)
    else $error("azimuth on positive x axis not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v_m2) && $stable(th_m2))
    else $error("pipeline moved during stall");

endmodule
